// ===== design/ida_pkg.sv =====
package ida_pkg;

   localparam int MAX_IDS = 4096;
   localparam int WORD_W  = 64;
   localparam int WORDS   = MAX_IDS / WORD_W;
   localparam int SLOT_W  = $clog2(MAX_IDS);
   localparam int ADDR_W  = $clog2(WORDS);
   localparam int BIT_W   = $clog2(WORD_W);
   localparam int COUNT_W = SLOT_W + 1;
   localparam int BASE_W  = 15;
   localparam int POOL_W  = 13;
   localparam int PID_W   = 16;

   localparam logic [1:0] MODE_ALLOC   = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_CLEAR   = 2'd2;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   localparam logic CSR_BASE_PID   = 1'b0;
   localparam logic CSR_POOL_COUNT = 1'b1;

   typedef logic [WORD_W-1:0] map_word_type;

endpackage

// ===== design/id_bitmap_allocator_unit.sv =====
// Channel   Direction  tdata                 tuser
// req_      in         [15:0] pid            [1:0] mode
// rsp_      out        [15:0] granted_pid    [1:0] status
// csr_      in         csr_index 0 base_pid [14:0], 1 pool_count [12:0]
//
// One request is in progress at a time. Release reads the map word in S_RD,
// clears the slot's bit in S_MOD and then passes S_FIN; clear, spare-mode,
// empty-pool and out-of-range requests go from accept straight to S_FIN.
// Allocate reads one 64-bit map word per cycle through the single read port
// (at most 65 words for a full pool) and passes S_FIN once it finds a free
// slot or none. Reset clears a row-valid flag per word, so the map is empty
// at once, with no clearing pass. A waiting result in the output register
// does not block accept; a request finishes only once that register is free.
module id_bitmap_allocator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pid
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] granted_pid
   output logic [1:0]  rsp_tuser,   // [1:0] status
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [14:0] csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_MOD  = 3'd3;
   localparam logic [2:0] S_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   logic [ida_pkg::BASE_W-1:0] base_ff;
   logic [ida_pkg::POOL_W-1:0] pool_ff;
   logic [ida_pkg::SLOT_W-1:0] last_slot_ff, last_slot_in;

   logic [ida_pkg::COUNT_W-1:0] n_ff, n_in;
   logic [ida_pkg::SLOT_W-1:0]  start_ff, start_in;
   logic [ida_pkg::ADDR_W-1:0]  lastw_ff, lastw_in;
   logic [ida_pkg::SLOT_W-1:0]  rel_slot_ff, rel_slot_in;

   logic [ida_pkg::ADDR_W-1:0] iss_w_ff, iss_w_in;
   logic                       iss_wrap_ff, iss_wrap_in;
   logic                       iss_on_ff, iss_on_in;
   logic                       ev_valid_ff, ev_valid_in;
   logic [ida_pkg::ADDR_W-1:0] ev_w_ff, ev_w_in;
   logic                       ev_wrap_ff, ev_wrap_in;

   logic [ida_pkg::PID_W-1:0] fin_pid_ff, fin_pid_in;
   logic [1:0]                fin_status_ff, fin_status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ida_pkg::PID_W-1:0] rsp_pid_ff, rsp_pid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;

   ida_pkg::map_word_type      map_mem [ida_pkg::WORDS];
   ida_pkg::map_word_type      rd_data_ff;
   logic                       rd_row_ok_ff;
   logic [ida_pkg::WORDS-1:0]  row_valid_ff, row_valid_in;

   logic                       rd_en, wr_en;
   logic [ida_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   ida_pkg::map_word_type      wr_data, rd_word, free_bits;

   logic [ida_pkg::COUNT_W-1:0] n_clamp, n_minus1;
   logic [ida_pkg::COUNT_W-1:0] lo, hi, slot_idx;
   logic [ida_pkg::PID_W:0]     rel_diff;
   logic                        rel_ok, found, ev_last;
   logic [ida_pkg::BIT_W-1:0]   bit_sel;
   ida_pkg::map_word_type       bit_hot;
   logic                        accept, out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pid_ff;
   assign rsp_tuser  = rsp_status_ff;

   assign rd_word = rd_row_ok_ff ? rd_data_ff : '0;

   // Pool size, clamped to the map depth.
   always_comb begin
      if (pool_ff > ida_pkg::POOL_W'(ida_pkg::MAX_IDS)) begin
         n_clamp = ida_pkg::COUNT_W'(ida_pkg::MAX_IDS);
      end else begin
         n_clamp = ida_pkg::COUNT_W'(pool_ff);
      end
      n_minus1 = n_clamp - ida_pkg::COUNT_W'(1);
      rel_diff = {1'b0, req_tdata} - {2'b00, base_ff};
      rel_ok   = !rel_diff[ida_pkg::PID_W]
                 && (rel_diff[ida_pkg::PID_W-1:0] < ida_pkg::PID_W'(n_clamp));
   end

   // Free-slot search in the word returned by the last read. Before the wrap
   // the window is [start, n), after it [0, start).
   always_comb begin
      lo = ev_wrap_ff ? '0 : {1'b0, start_ff};
      hi = ev_wrap_ff ? {1'b0, start_ff} : n_ff;
      free_bits = '0;
      for (int b = 0; b < ida_pkg::WORD_W; b++) begin
         slot_idx = {1'b0, ev_w_ff, b[ida_pkg::BIT_W-1:0]};
         free_bits[b] = !rd_word[b] && (slot_idx >= lo) && (slot_idx < hi);
      end
      found   = 1'b0;
      bit_sel = '0;
      for (int b = ida_pkg::WORD_W - 1; b >= 0; b--) begin
         if (free_bits[b]) begin
            found   = 1'b1;
            bit_sel = b[ida_pkg::BIT_W-1:0];
         end
      end
      ev_last = ev_wrap_ff && (ev_w_ff == start_ff[ida_pkg::SLOT_W-1 -: ida_pkg::ADDR_W]);
   end

   always_comb begin
      state_in      = state_ff;
      last_slot_in  = last_slot_ff;
      n_in          = n_ff;
      start_in      = start_ff;
      lastw_in      = lastw_ff;
      rel_slot_in   = rel_slot_ff;
      iss_w_in      = iss_w_ff;
      iss_wrap_in   = iss_wrap_ff;
      iss_on_in     = iss_on_ff;
      ev_valid_in   = 1'b0;
      ev_w_in       = iss_w_ff;
      ev_wrap_in    = iss_wrap_ff;
      fin_pid_in    = fin_pid_ff;
      fin_status_in = fin_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_pid_in    = rsp_pid_ff;
      rsp_status_in = rsp_status_ff;
      row_valid_in  = row_valid_ff;
      rd_en         = 1'b0;
      rd_addr       = iss_w_ff;
      wr_en         = 1'b0;
      wr_addr       = ev_w_ff;
      wr_data       = rd_word;
      bit_hot       = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               n_in          = n_clamp;
               start_in      = (ida_pkg::COUNT_W'(last_slot_ff) < n_clamp) ? last_slot_ff : '0;
               lastw_in      = n_minus1[ida_pkg::SLOT_W-1 -: ida_pkg::ADDR_W];
               rel_slot_in   = rel_diff[ida_pkg::SLOT_W-1:0];
               fin_pid_in    = '0;
               fin_status_in = ida_pkg::ST_DONE;
               state_in      = S_FIN;
               case (req_tuser)
                  ida_pkg::MODE_ALLOC: begin
                     if (n_clamp == '0) begin
                        fin_status_in = ida_pkg::ST_FULL;
                     end else begin
                        iss_w_in    = start_in[ida_pkg::SLOT_W-1 -: ida_pkg::ADDR_W];
                        iss_wrap_in = 1'b0;
                        iss_on_in   = 1'b1;
                        state_in    = S_SCAN;
                     end
                  end
                  ida_pkg::MODE_RELEASE: begin
                     if (rel_ok) begin
                        state_in = S_RD;
                     end else begin
                        fin_status_in = ida_pkg::ST_RANGE;
                     end
                  end
                  ida_pkg::MODE_CLEAR: begin
                     row_valid_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // One word read is issued per cycle; the evaluation uses the registered read data.
            if (iss_on_ff) begin
               rd_en       = 1'b1;
               ev_valid_in = 1'b1;
               if (!iss_wrap_ff && (iss_w_ff == lastw_ff)) begin
                  iss_w_in    = '0;
                  iss_wrap_in = 1'b1;
               end else begin
                  iss_w_in = iss_w_ff + ida_pkg::ADDR_W'(1);
               end
               if (iss_wrap_ff
                   && (iss_w_ff == start_ff[ida_pkg::SLOT_W-1 -: ida_pkg::ADDR_W])) begin
                  iss_on_in = 1'b0;
               end
            end
            if (ev_valid_ff && found) begin
               bit_hot               = '0;
               bit_hot[bit_sel]      = 1'b1;
               wr_en                 = 1'b1;
               wr_data               = rd_word | bit_hot;
               row_valid_in[ev_w_ff] = 1'b1;
               last_slot_in          = {ev_w_ff, bit_sel};
               fin_pid_in            = {1'b0, base_ff}
                                       + ida_pkg::PID_W'({ev_w_ff, bit_sel});
               fin_status_in         = ida_pkg::ST_DONE;
               iss_on_in             = 1'b0;
               ev_valid_in           = 1'b0;
               state_in              = S_FIN;
            end else if (ev_valid_ff && ev_last) begin
               fin_status_in = ida_pkg::ST_FULL;
               iss_on_in     = 1'b0;
               ev_valid_in   = 1'b0;
               state_in      = S_FIN;
            end
         end
         S_RD: begin
            rd_en    = 1'b1;
            rd_addr  = rel_slot_ff[ida_pkg::SLOT_W-1 -: ida_pkg::ADDR_W];
            state_in = S_MOD;
         end
         S_MOD: begin
            bit_hot                     = '0;
            bit_hot[rel_slot_ff[ida_pkg::BIT_W-1:0]] = 1'b1;
            wr_en                       = 1'b1;
            wr_addr                     = rel_slot_ff[ida_pkg::SLOT_W-1 -: ida_pkg::ADDR_W];
            wr_data                     = rd_word & ~bit_hot;
            row_valid_in[wr_addr]       = 1'b1;
            state_in                    = S_FIN;
         end
         S_FIN: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_pid_in    = fin_pid_ff;
               rsp_status_in = fin_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff   <= map_mem[rd_addr];
         rd_row_ok_ff <= row_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= ida_pkg::BASE_W'(300);
         pool_ff      <= ida_pkg::POOL_W'(ida_pkg::MAX_IDS);
         last_slot_ff <= '0;
         row_valid_ff <= '0;
         iss_on_ff    <= 1'b0;
         ev_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         last_slot_ff <= last_slot_in;
         row_valid_ff <= row_valid_in;
         iss_on_ff    <= iss_on_in;
         ev_valid_ff  <= ev_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            if (csr_index == ida_pkg::CSR_BASE_PID) begin
               base_ff <= csr_wdata;
            end else begin
               pool_ff <= csr_wdata[ida_pkg::POOL_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      start_ff      <= start_in;
      lastw_ff      <= lastw_in;
      rel_slot_ff   <= rel_slot_in;
      iss_w_ff      <= iss_w_in;
      iss_wrap_ff   <= iss_wrap_in;
      ev_w_ff       <= ev_w_in;
      ev_wrap_ff    <= ev_wrap_in;
      fin_pid_ff    <= fin_pid_in;
      fin_status_ff <= fin_status_in;
      rsp_pid_ff    <= rsp_pid_in;
      rsp_status_ff <= rsp_status_in;
   end

endmodule

// ===== design/ida_checker.sv =====
module ida_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // A held result keeps its word until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Only one request is worked on at a time.
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ida_pkg::ST_DONE) || (rsp_tuser == ida_pkg::ST_FULL)
                     || (rsp_tuser == ida_pkg::ST_RANGE))
      else $error("unknown status");

   // No id is reported together with a failure status.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ida_pkg::ST_DONE) |-> rsp_tdata == 16'd0)
      else $error("id returned with failure status");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("not idle after reset");

endmodule

bind id_bitmap_allocator_unit ida_checker u_ida_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
